// ===== rtl/lpfc_pkg.sv =====
// shared types and constants of the length-prefixed frame checker
package lpfc_pkg;

  localparam int unsigned CFG_W     = 27;
  localparam int unsigned CNT_W     = 27;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] LEN_FLOOR = 32'd8;
  localparam logic [31:0] NAME_MIN  = 32'd2;
  localparam logic [31:0] TRAIL_LEN = 32'd4;
  localparam logic [31:0] NAME_ROOM = 32'd8;
  localparam logic [15:0] SUM_LO_INIT = 16'd1;

  localparam logic CFG_MIN_LEN = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_BODY,
    PH_TRAIL,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_LEN,
    ST_BAD_SUM,
    ST_BAD_NAME
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] frame_len;
    logic signed [31:0] name_len;
    logic [31:0]        computed_sum;
  } result_t;

endpackage

// ===== rtl/lpfc_if.sv =====
// stream interfaces for byte requests and status results
interface lpfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface lpfc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] frame_len;
  logic signed [31:0] name_len;
  logic [31:0]        computed_sum;

  modport source (output valid, output status, output frame_len, output name_len,
                  output computed_sum, input ready);
  modport sink (input valid, input status, input frame_len, input name_len,
                input computed_sum, output ready);
endinterface

// ===== rtl/lpfc_in_stage.sv =====
// input register holding one byte request
module lpfc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  lpfc_in_if.sink            in_i,
  input  logic               take_i,
  output logic               item_valid_o,
  output lpfc_pkg::in_item_t item_o
);
  import lpfc_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.restart   <= in_i.restart;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/lpfc_framer.sv =====
// framer state, running adler-32 and frame checks
module lpfc_framer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  lpfc_pkg::in_item_t         item_i,
  input  logic [lpfc_pkg::CFG_W-1:0] min_len_i,
  input  logic [lpfc_pkg::CFG_W-1:0] max_len_i,
  output logic                       res_valid_o,
  output lpfc_pkg::result_t          res_o
);
  import lpfc_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      len_q, len_d;
  logic [31:0]      nl_q, nl_d;
  logic [15:0]      lo_q, lo_d;
  logic [15:0]      hi_q, hi_d;
  logic [31:0]      tr_q, tr_d;

  logic [31:0]      len_shift, tr_shift;
  logic [16:0]      lo_add, hi_add;
  logic [15:0]      lo_new, hi_new;
  logic [CNT_W-1:0] cnt_inc;
  logic             len_last, len_ok, body_last, trail_last, sum_ok, name_ok;
  logic [31:0]      sum;

  // datapath terms
  always_comb begin
    len_shift  = {len_q[23:0], item_i.data_byte};
    tr_shift   = {tr_q[23:0], item_i.data_byte};
    cnt_inc    = cnt_q + 1'b1;
    len_last   = (cnt_q == CNT_W'(3));
    trail_last = (cnt_q == CNT_W'(3));
    len_ok     = !len_shift[31] &&
                 (len_shift >= {{(32 - CFG_W){1'b0}}, min_len_i}) &&
                 (len_shift <= {{(32 - CFG_W){1'b0}}, max_len_i}) &&
                 (len_shift >= LEN_FLOOR);
    lo_add     = {1'b0, lo_q} + {9'd0, item_i.data_byte};
    lo_new     = (lo_add >= ADLER_MOD) ? 16'(lo_add - ADLER_MOD) : lo_add[15:0];
    hi_add     = {1'b0, hi_q} + {1'b0, lo_new};
    hi_new     = (hi_add >= ADLER_MOD) ? 16'(hi_add - ADLER_MOD) : hi_add[15:0];
    body_last  = (cnt_inc == CNT_W'(len_q - TRAIL_LEN));
    sum        = {hi_q, lo_q};
    sum_ok     = (sum == tr_shift);
    name_ok    = !($signed(nl_q) < $signed(NAME_MIN)) &&
                 !($signed(nl_q) > $signed(len_q - NAME_ROOM));
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    if (item_i.restart) begin
      phase_d = PH_LEN;
    end else begin
      case (phase_q)
        PH_LEN: begin
          if (len_last) phase_d = len_ok ? PH_BODY : PH_HALT;
        end
        PH_BODY: begin
          if (body_last) phase_d = PH_TRAIL;
        end
        PH_TRAIL: begin
          if (trail_last) phase_d = (sum_ok && name_ok) ? PH_LEN : PH_HALT;
        end
        default: phase_d = PH_HALT;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    cnt_d = cnt_q;
    len_d = len_q;
    nl_d  = nl_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    tr_d  = tr_q;
    res_valid_o        = 1'b0;
    res_o.status       = ST_OK;
    res_o.frame_len    = len_q;
    res_o.name_len     = nl_q;
    res_o.computed_sum = sum;
    if (item_i.restart) begin
      cnt_d = '0;
      len_d = '0;
      nl_d  = '0;
      lo_d  = SUM_LO_INIT;
      hi_d  = '0;
      tr_d  = '0;
    end else begin
      case (phase_q)
        PH_LEN: begin
          len_d = len_shift;
          cnt_d = cnt_inc;
          if (len_last) begin
            cnt_d = '0;
            nl_d  = '0;
            lo_d  = SUM_LO_INIT;
            hi_d  = '0;
            if (!len_ok) begin
              res_valid_o        = 1'b1;
              res_o.status       = ST_BAD_LEN;
              res_o.frame_len    = len_shift;
              res_o.name_len     = '0;
              res_o.computed_sum = '0;
            end
          end
        end
        PH_BODY: begin
          if (cnt_q < CNT_W'(4)) nl_d = {nl_q[23:0], item_i.data_byte};
          lo_d  = lo_new;
          hi_d  = hi_new;
          cnt_d = cnt_inc;
          if (body_last) begin
            cnt_d = '0;
            tr_d  = '0;
          end
        end
        PH_TRAIL: begin
          tr_d  = tr_shift;
          cnt_d = cnt_inc;
          if (trail_last) begin
            cnt_d       = '0;
            res_valid_o = 1'b1;
            if (!sum_ok) begin
              res_o.status = ST_BAD_SUM;
            end else if (!name_ok) begin
              res_o.status = ST_BAD_NAME;
            end else begin
              res_o.status = ST_OK;
              len_d        = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      cnt_q   <= '0;
      len_q   <= '0;
      nl_q    <= '0;
      lo_q    <= SUM_LO_INIT;
      hi_q    <= '0;
      tr_q    <= '0;
    end else if (go_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      nl_q    <= nl_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      tr_q    <= tr_d;
    end
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.restart |=> phase_q == PH_LEN && lo_q == SUM_LO_INIT && hi_q == '0)
    else $error("restart did not clear the framer");

  a_sum_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, lo_q} < ADLER_MOD && {1'b0, hi_q} < ADLER_MOD)
    else $error("adler-32 sum not reduced");

  a_no_result_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> phase_q != PH_HALT && !item_i.restart)
    else $error("result while halted or on restart");

endmodule

// ===== rtl/lpfc_out_stage.sv =====
// result register driving the status channel
module lpfc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lpfc_pkg::result_t res_i,
  output logic              free_o,
  lpfc_out_if.source        out_o
);
  import lpfc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.frame_len    = res_q.frame_len;
  assign out_o.name_len     = res_q.name_len;
  assign out_o.computed_sum = res_q.computed_sum;

endmodule

// ===== rtl/length_prefixed_frame_checker_core.sv =====
// Length-prefixed frame checker: one byte request per cycle, sustained while no
// result is held up by the status channel. Each byte passes an input register,
// the framing logic (the Adler-32 add and reduce chain and the length compares)
// and a result register. Bytes that produce no result keep flowing while a result
// waits; a byte that ends a frame waits in the input register until the result
// register is free. Limit registers are written through the plain write port; the
// user must do so only while the block is idle, as the block does not enforce it.
module length_prefixed_frame_checker_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lpfc_in_if.sink                    in_i,
  lpfc_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [lpfc_pkg::CFG_W-1:0] cfg_data_i
);
  import lpfc_pkg::*;

  logic [CFG_W-1:0] min_len_q, max_len_q;
  logic             item_valid, take, res_valid, out_free;
  in_item_t         item;
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= CFG_W'(10);
      max_len_q <= CFG_W'(67108864);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LEN: min_len_q <= cfg_data_i;
        CFG_MAX_LEN: max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign take = item_valid && (!res_valid || out_free);

  lpfc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lpfc_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (take),
    .item_i      (item),
    .min_len_i   (min_len_q),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfc_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the length-prefixed frame checker: framed byte requests in, statuses out
module tb_top;
  import lpfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned SEG_BYTES    = 155;
  localparam int unsigned DIR_N        = 20;
  localparam int unsigned SEG_N        = 6;
  localparam logic [26:0] LEN_TOP      = 27'd67108864;
  localparam logic [31:0] FIELD_BYTES  = 32'd4;
  localparam int          FILL_RAND    = 0;
  localparam int          FILL_ONES    = 1;
  localparam int          FILL_ZERO    = 2;

  typedef struct {
    in_item_t item;
    bit       typed;
    result_t  exp;
  } byte_req_t;

  typedef struct packed {
    logic [26:0] min_len;
    logic [26:0] max_len;
    logic [31:0] flen;
    logic [31:0] nlen;
    bit          bad_sum;
    int          cut;
    bit          typed;
  } frame_row_t;

  // typed rows carry an obvious bad-length status: {ST_BAD_LEN, flen, 0, 0}
  localparam frame_row_t DIR_ROWS [DIR_N] = '{
    '{27'd10, LEN_TOP, 32'd10,          32'd2,          1'b0, -1, 1'b0},
    '{27'd10, LEN_TOP, 32'd9,           32'd0,          1'b0, -1, 1'b1},
    '{27'd10, LEN_TOP, 32'd67108865,    32'd0,          1'b0, -1, 1'b1},
    '{27'd10, LEN_TOP, 32'h8000_0000,   32'd0,          1'b0, -1, 1'b1},
    '{27'd10, LEN_TOP, 32'hFFFF_FFFF,   32'd0,          1'b0, -1, 1'b1},
    '{27'd10, LEN_TOP, 32'd12,          32'd4,          1'b0, -1, 1'b0},
    '{27'd10, LEN_TOP, 32'd12,          32'd1,          1'b0, -1, 1'b0},
    '{27'd10, LEN_TOP, 32'd12,          32'd5,          1'b0, -1, 1'b0},
    '{27'd10, LEN_TOP, 32'd12,          32'h8000_0000,  1'b0, -1, 1'b0},
    '{27'd10, LEN_TOP, 32'd16,          32'd3,          1'b1, -1, 1'b0},
    '{27'd10, LEN_TOP, 32'd67108864,    32'd2,          1'b0,  6, 1'b0},
    '{27'd10, LEN_TOP, 32'd20,          32'd2,          1'b0,  2, 1'b0},
    '{27'd10, LEN_TOP, 32'h7FFF_FFFF,   32'd0,          1'b0, -1, 1'b1},
    '{27'd10, 27'd10,  32'd10,          32'd2,          1'b0, -1, 1'b0},
    '{27'd10, 27'd10,  32'd11,          32'd2,          1'b0, -1, 1'b1},
    '{27'd20, 27'd15,  32'd18,          32'd2,          1'b0, -1, 1'b1},
    '{27'd0,  LEN_TOP, 32'd7,           32'd0,          1'b0, -1, 1'b1},
    '{27'd0,  LEN_TOP, 32'd8,           32'd0,          1'b0, -1, 1'b0},
    '{LEN_TOP, LEN_TOP, 32'd67108863,   32'd0,          1'b0, -1, 1'b1},
    '{LEN_TOP, LEN_TOP, 32'd67108864,   32'd2,          1'b0,  6, 1'b0}
  };

  localparam logic [26:0] SEG_MIN [SEG_N] = '{27'd10, 27'd12, 27'd10, LEN_TOP, 27'd25, 27'd10};
  localparam logic [26:0] SEG_MAX [SEG_N] = '{LEN_TOP, 27'd30, 27'd300, LEN_TOP, 27'd20, 27'd400};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic        cfg_idx;
  logic [26:0] cfg_data;

  lpfc_in_if  in_bus ();
  lpfc_out_if out_bus ();

  length_prefixed_frame_checker_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_req_t   byte_q[$];
  result_t     frame_status_q[$];
  bit          req_busy = 1'b0;
  int unsigned tx_idle = 36;
  int unsigned rx_idle = 57;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // framer image
  phase_e      fr_phase;
  logic [31:0] fr_cnt;
  logic [31:0] fr_len;
  logic [31:0] fr_nlen;
  logic [31:0] fr_trail;
  logic [15:0] fr_lo;
  logic [15:0] fr_hi;
  logic [26:0] lim_min;
  logic [26:0] lim_max;

  function automatic void clear_frame_state();
    fr_phase = PH_LEN;
    fr_cnt   = '0;
    fr_len   = '0;
    fr_nlen  = '0;
    fr_trail = '0;
    fr_lo    = SUM_LO_INIT;
    fr_hi    = '0;
  endfunction

  function automatic bit len_ok(input logic [31:0] l);
    longint ls;
    ls = longint'($signed(l));
    return !(ls < longint'(lim_min) || ls > longint'(lim_max) || ls < longint'(LEN_FLOOR));
  endfunction

  function automatic bit name_ok(input logic [31:0] l, input logic [31:0] n);
    longint ls;
    longint nl;
    ls = longint'($signed(l));
    nl = longint'($signed(n));
    return (nl >= longint'(NAME_MIN)) && (nl <= ls - longint'(NAME_ROOM));
  endfunction

  function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ADLER_MOD) s = s - ADLER_MOD;
    return s[15:0];
  endfunction

  function automatic bit step_framer(input in_item_t it, output result_t res);
    logic [31:0] sum;
    res = '0;
    if (it.restart) begin
      clear_frame_state();
      return 1'b0;
    end
    case (fr_phase)
      PH_LEN: begin
        fr_len = {fr_len[23:0], it.data_byte};
        fr_cnt = fr_cnt + 1;
        if (fr_cnt < FIELD_BYTES) return 1'b0;
        fr_cnt = '0;
        if (!len_ok(fr_len)) begin
          fr_phase      = PH_HALT;
          res.status    = ST_BAD_LEN;
          res.frame_len = fr_len;
          return 1'b1;
        end
        fr_phase = PH_BODY;
        fr_nlen  = '0;
        fr_lo    = SUM_LO_INIT;
        fr_hi    = '0;
        return 1'b0;
      end
      PH_BODY: begin
        if (fr_cnt < FIELD_BYTES) fr_nlen = {fr_nlen[23:0], it.data_byte};
        fr_lo  = mod_add(fr_lo, {8'd0, it.data_byte});
        fr_hi  = mod_add(fr_hi, fr_lo);
        fr_cnt = fr_cnt + 1;
        if (fr_cnt >= fr_len - TRAIL_LEN) begin
          fr_cnt   = '0;
          fr_trail = '0;
          fr_phase = PH_TRAIL;
        end
        return 1'b0;
      end
      PH_TRAIL: begin
        fr_trail = {fr_trail[23:0], it.data_byte};
        fr_cnt   = fr_cnt + 1;
        if (fr_cnt < FIELD_BYTES) return 1'b0;
        fr_cnt           = '0;
        sum              = {fr_hi, fr_lo};
        res.frame_len    = fr_len;
        res.name_len     = fr_nlen;
        res.computed_sum = sum;
        if (sum != fr_trail) begin
          fr_phase   = PH_HALT;
          res.status = ST_BAD_SUM;
        end else if (!name_ok(fr_len, fr_nlen)) begin
          fr_phase   = PH_HALT;
          res.status = ST_BAD_NAME;
        end else begin
          fr_phase   = PH_LEN;
          res.status = ST_OK;
          fr_len     = '0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b, input bit rs, input bit typed,
                                    input result_t r);
    byte_req_t q;
    q.item.data_byte = b;
    q.item.restart   = rs;
    q.typed          = typed;
    q.exp            = r;
    byte_q.push_back(q);
  endfunction

  // junk while halted, then restart
  function automatic void push_restart_tail();
    int n;
    n = $urandom_range(3, 0);
    repeat (n) push_byte(8'($urandom), 1'b0, 1'b0, '0);
    push_byte(8'($urandom), 1'b1, 1'b0, '0);
  endfunction

  // queues one frame; cut >= 0 aborts with a restart after that many bytes
  function automatic bit emit_frame(input logic [31:0] flen, input logic [31:0] nlen,
                                    input int fill, input bit bad_sum, input int cut,
                                    input bit typed);
    int          i;
    int          n;
    int          sent;
    int unsigned a;
    int unsigned s;
    logic [7:0]  b;
    logic [31:0] trail;
    result_t     r;
    r           = '0;
    r.status    = ST_BAD_LEN;
    r.frame_len = flen;
    sent        = 0;
    trail       = '0;
    for (i = 0; i < 4; i++) begin
      if (cut >= 0 && sent == cut) begin
        push_byte(8'($urandom), 1'b1, 1'b0, '0);
        return 1'b0;
      end
      push_byte(flen[31-8*i -: 8], 1'b0, typed && (i == 3), r);
      sent++;
    end
    if (!len_ok(flen)) return 1'b1;
    n = int'(flen) - 4;
    a = 1;
    s = 0;
    for (i = 0; i < n + 4; i++) begin
      if (cut >= 0 && sent == cut) begin
        push_byte(8'($urandom), 1'b1, 1'b0, '0);
        return 1'b0;
      end
      if (i >= n) b = trail[31-8*(i-n) -: 8];
      else if (i < 4) b = nlen[31-8*i -: 8];
      else if (fill == FILL_ONES) b = 8'hFF;
      else if (fill == FILL_ZERO) b = 8'h00;
      else b = 8'($urandom);
      if (i < n) begin
        a = (a + b) % int'(ADLER_MOD);
        s = (s + a) % int'(ADLER_MOD);
      end
      if (i == n - 1) begin
        trail = {s[15:0], a[15:0]};
        if (bad_sum) trail = trail ^ (32'd1 << $urandom_range(31, 0));
      end
      push_byte(b, 1'b0, 1'b0, '0);
      sent++;
    end
    return bad_sum || !name_ok(flen, nlen);
  endfunction

  function automatic void gen_random_frame();
    int unsigned lo;
    int unsigned hi;
    int unsigned top;
    int unsigned pick;
    logic [31:0] flen;
    logic [31:0] nlen;
    int          fill;
    int          cut;
    int          n;
    bit          fits;
    bit          err;
    lo   = (32'(lim_min) < LEN_FLOOR) ? LEN_FLOOR : 32'(lim_min);
    hi   = 32'(lim_max);
    fits = (lo <= hi) && (lo <= 1000);
    top  = (hi > lo + 30) ? lo + 30 : hi;
    fill = ($urandom_range(19, 0) == 0) ? FILL_ZERO : FILL_RAND;
    cut  = -1;
    pick = $urandom_range(99, 0);
    if (!fits && pick < 85) pick = 85;
    flen = fits ? $urandom_range(top, lo) : 32'($urandom_range(40, 8));
    if (pick < 65 && hi >= 300 && lo <= 260 && $urandom_range(24, 0) == 0) begin
      flen = $urandom_range(300, 260);
      fill = FILL_ONES;
    end
    nlen = $urandom_range(flen - 8, 2);
    if (pick >= 65 && pick < 75) begin
      case ($urandom_range(4, 0))
        0: nlen = 32'd0;
        1: nlen = 32'd1;
        2: nlen = flen - 7;
        3: nlen = {1'b1, 31'($urandom)};
        default: nlen = flen - 7 + $urandom_range(1000, 0);
      endcase
    end
    if (pick >= 85 && pick < 90) begin
      case ($urandom_range(3, 0))
        0: flen = {1'b1, 31'($urandom)};
        1: flen = hi + 1;
        2: flen = (lo > 0) ? lo - 1 : hi + 1;
        default: flen = $urandom_range(7, 0);
      endcase
    end
    if (pick >= 90 && pick < 95) cut = fits ? $urandom_range(flen + 3, 0) : $urandom_range(3, 0);
    if (pick >= 95) begin
      n = $urandom_range(12, 1);
      repeat (n) push_byte(8'($urandom), 1'b0, 1'b0, '0);
      push_byte(8'($urandom), 1'b1, 1'b0, '0);
      return;
    end
    err = emit_frame(flen, nlen, fill, pick >= 75 && pick < 85, cut, 1'b0);
    if (err) push_restart_tail();
    else if ($urandom_range(19, 0) == 0) push_byte(8'($urandom), 1'b1, 1'b0, '0);
  endfunction

  task automatic wait_idle();
    while (byte_q.size() != 0 || req_busy || frame_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [26:0] mn, input logic [26:0] mx);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MIN_LEN;
    cfg_data <= mn;
    @(posedge clk);
    cfg_idx  <= CFG_MAX_LEN;
    cfg_data <= mx;
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim_min = mn;
    lim_max = mx;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // byte request driver and predictor
  initial begin
    byte_req_t cur;
    result_t   res;
    bit        hit;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.restart   <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (in_bus.valid && in_bus.ready) begin
        hit = step_framer(cur.item, res);
        if (cur.typed) frame_status_q.push_back(cur.exp);
        else if (hit) frame_status_q.push_back(res);
        req_busy = 1'b0;
      end
      if (!req_busy) begin
        if (byte_q.size() != 0 && $urandom_range(99, 0) >= tx_idle) begin
          cur = byte_q.pop_front();
          req_busy = 1'b1;
          in_bus.valid     <= 1'b1;
          in_bus.data_byte <= cur.item.data_byte;
          in_bus.restart   <= cur.item.restart;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99, 0) >= rx_idle);
    end
  end

  always @(posedge clk) begin : status_check
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (frame_status_q.size() == 0) begin
        $display("%0t: unexpected status, expected none, actual %0d len %0h name %0h sum %0h",
                 $time, out_bus.status, out_bus.frame_len, out_bus.name_len,
                 out_bus.computed_sum);
        mismatch_cnt++;
      end else begin
        want = frame_status_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_bus.status));
        check_field("frame_len", want.frame_len, out_bus.frame_len);
        check_field("name_len", want.name_len, out_bus.name_len);
        check_field("computed_sum", want.computed_sum, out_bus.computed_sum);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    frame_row_t  row;
    bit          err;
    int unsigned start;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_MIN_LEN;
    cfg_data <= '0;
    lim_min = 27'd10;
    lim_max = LEN_TOP;
    clear_frame_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.min_len != lim_min || row.max_len != lim_max) begin
        wait_idle();
        set_limits(row.min_len, row.max_len);
      end
      err = emit_frame(row.flen, row.nlen, FILL_RAND, row.bad_sum, row.cut, row.typed);
      if (err) push_restart_tail();
    end

    for (int seg = 0; seg < SEG_N; seg++) begin
      wait_idle();
      if (seg < 2) begin
        tx_idle = 36;
        rx_idle = 57;
      end else if (seg < 4) begin
        tx_idle = 57;
        rx_idle = 36;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      set_limits(SEG_MIN[seg], SEG_MAX[seg]);
      start = byte_q.size();
      while (byte_q.size() - start < SEG_BYTES) gen_random_frame();
    end

    wait_idle();
    if (mismatch_cnt == 0 && frame_status_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lpfc_pkg.sv
rtl/lpfc_if.sv
rtl/lpfc_in_stage.sv
rtl/lpfc_framer.sv
rtl/lpfc_out_stage.sv
rtl/length_prefixed_frame_checker_core.sv
bench/tb_top.sv
